// File: rtl/core/tlwbc_pkg.sv
`timescale 1ns / 1ps

package tlwbc_pkg;

    localparam int BLOCK_WORDS   = 16;
    localparam int L1_LINE_COUNT = 16;
    localparam int L2_LINE_COUNT = 128;
    localparam int MEMORY_WORDS  = 32768;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 15;
    localparam int OFF_W     = $clog2(BLOCK_WORDS);
    localparam int CNT_W     = OFF_W + 1;
    localparam int L1_IDX_W  = $clog2(L1_LINE_COUNT);
    localparam int L1_TAG_W  = ADDR_W - OFF_W - L1_IDX_W;
    localparam int L2_IDX_W  = $clog2(L2_LINE_COUNT);
    localparam int L2_TAG_W  = ADDR_W - OFF_W - L2_IDX_W;
    localparam int COST_W    = 10;
    localparam int ACC_W     = 13;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_RD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_WR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_RD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_RD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WR   = 3'd5;

    typedef struct packed {
        logic [COST_W-1:0] dram_rd;
        logic [COST_W-1:0] dram_wr;
        logic [COST_W-1:0] l2_rd;
        logic [COST_W-1:0] l2_wr;
        logic [COST_W-1:0] l1_rd;
        logic [COST_W-1:0] l1_wr;
    } t_costs;

endpackage

// File: rtl/core/tlwbc_ram.sv
`timescale 1ns / 1ps

module tlwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tlwbc_cfg.sv
`timescale 1ns / 1ps

module tlwbc_cfg
    import tlwbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COST_W-1:0]    i_cfg_data,
    output t_costs               o_costs
);

    t_costs r_costs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_costs.dram_rd <= COST_W'(100);
            r_costs.dram_wr <= COST_W'(50);
            r_costs.l2_rd   <= COST_W'(10);
            r_costs.l2_wr   <= COST_W'(5);
            r_costs.l1_rd   <= COST_W'(1);
            r_costs.l1_wr   <= COST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRAM_RD: r_costs.dram_rd <= i_cfg_data;
                CFG_DRAM_WR: r_costs.dram_wr <= i_cfg_data;
                CFG_L2_RD:   r_costs.l2_rd   <= i_cfg_data;
                CFG_L2_WR:   r_costs.l2_wr   <= i_cfg_data;
                CFG_L1_RD:   r_costs.l1_rd   <= i_cfg_data;
                CFG_L1_WR:   r_costs.l1_wr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_costs = r_costs;

endmodule

// File: rtl/core/two_level_write_back_cache_core.sv
`timescale 1ns / 1ps
// one word at a time; an l1 hit passes lookup, the word state and, for a read, the
// word read state before done; a miss copies blocks one word per cycle through rams
// with one read and one write port, from l2 when it hits, else from dram, and dirty
// victims at either level are written back; next word is taken the cycle after the
// result enters the output register; synchronous reset clears valid and dirty bits
// and the total, sets default costs, then zeroes all of dram while input stays stalled

module two_level_write_back_cache_core
    import tlwbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COST_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ADDR_W-1:0]    i_word_address,
    input  logic [DATA_W-1:0]    i_write_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_data,
    output logic                 o_l1_hit,
    output logic                 o_l2_hit,
    output logic [ACC_W-1:0]     o_access_cost,
    output logic [DATA_W-1:0]    o_elapsed_time,
    output logic                 o_address_error
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_L2_TAG, S_L2_CHK, S_L2_RD, S_DR_RD, S_WB2,
        S_L2_INST, S_L1_TO_L2, S_L1_INST, S_WORD, S_WORD_RD, S_DONE
    } t_state;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(BLOCK_WORDS);

    t_costs costs;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr;
    logic [ACT_W-1:0]      r_act;
    logic [ADDR_W-1:0]     r_addr;
    logic [DATA_W-1:0]     r_wdata;
    logic [ADDR_W-1:0]     r_l2_addr;
    logic                  r_l2_wr;
    logic                  r_vdirty2;
    logic [L2_TAG_W-1:0]   r_vtag2;
    logic                  r_l1vd;
    logic [L1_TAG_W-1:0]   r_vtag1;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_wv;
    logic [OFF_W-1:0]      r_widx;
    logic [DATA_W-1:0]     r_buf [BLOCK_WORDS];
    logic [L1_TAG_W-1:0]   r_l1_tag [L1_LINE_COUNT];
    logic [L1_LINE_COUNT-1:0] r_l1_valid;
    logic [L1_LINE_COUNT-1:0] r_l1_dirty;
    logic [L2_LINE_COUNT-1:0] r_l2_valid;
    logic [L2_LINE_COUNT-1:0] r_l2_dirty;
    logic [DATA_W-1:0]     r_total;
    logic [DATA_W-1:0]     r_rdata;
    logic                  r_h1;
    logic                  r_h2;
    logic [ACC_W-1:0]      r_cost;
    logic                  r_err;
    logic                  r_clear;
    logic                  r_charge;
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_rdata;
    logic                  r_out_h1;
    logic                  r_out_h2;
    logic [ACC_W-1:0]      r_out_cost;
    logic [DATA_W-1:0]     r_out_time;
    logic                  r_out_err;

    logic [OFF_W-1:0]    off;
    logic [L1_IDX_W-1:0] l1_idx;
    logic [L1_TAG_W-1:0] l1_tag;
    logic [L2_IDX_W-1:0] l2_idx;
    logic [L2_TAG_W-1:0] l2_tag;
    logic [OFF_W-1:0]    cidx;
    logic                cnt_run;
    logic                l2_hit;
    logic                out_free;
    logic [DATA_W-1:0]   n_total;

    logic                          l1_we;
    logic [L1_IDX_W+OFF_W-1:0]     l1_waddr;
    logic [L1_IDX_W+OFF_W-1:0]     l1_raddr;
    logic [DATA_W-1:0]             l1_wdata;
    logic [DATA_W-1:0]             l1_q;
    logic                          l2_we;
    logic [L2_IDX_W+OFF_W-1:0]     l2_waddr;
    logic [L2_IDX_W+OFF_W-1:0]     l2_raddr;
    logic [DATA_W-1:0]             l2_wdata;
    logic [DATA_W-1:0]             l2_q;
    logic                          tag_we;
    logic [L2_TAG_W-1:0]           tag_q;
    logic                          dr_we;
    logic [ADDR_W-1:0]             dr_waddr;
    logic [ADDR_W-1:0]             dr_raddr;
    logic [DATA_W-1:0]             dr_wdata;
    logic [DATA_W-1:0]             dr_q;

    tlwbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_costs     (costs)
    );

    assign off     = r_addr[OFF_W-1:0];
    assign l1_idx  = r_addr[OFF_W +: L1_IDX_W];
    assign l1_tag  = r_addr[ADDR_W-1 -: L1_TAG_W];
    assign l2_idx  = r_l2_addr[OFF_W +: L2_IDX_W];
    assign l2_tag  = r_l2_addr[ADDR_W-1 -: L2_TAG_W];
    assign cidx    = r_cnt[OFF_W-1:0];
    assign cnt_run = (r_cnt != CNT_END);
    assign l2_hit  = r_l2_valid[l2_idx] && (tag_q == l2_tag);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_clear) begin
            n_total = '0;
        end else if (r_charge) begin
            n_total = r_total + DATA_W'(r_cost);
        end else begin
            n_total = r_total;
        end
    end

    // ram port steering
    always_comb begin
        l1_we    = 1'b0;
        l1_waddr = {l1_idx, cidx};
        l1_wdata = r_buf[cidx];
        l1_raddr = {l1_idx, cidx};
        l2_we    = 1'b0;
        l2_waddr = {l2_idx, cidx};
        l2_wdata = r_buf[cidx];
        l2_raddr = {l2_idx, cidx};
        tag_we   = (r_state == S_L2_CHK) && !l2_hit;
        dr_we    = 1'b0;
        dr_waddr = {r_vtag2, l2_idx, r_widx};
        dr_wdata = l2_q;
        dr_raddr = {r_l2_addr[ADDR_W-1:OFF_W], cidx};
        case (r_state)
            S_CLR: begin
                dr_we    = 1'b1;
                dr_waddr = r_clr;
                dr_wdata = '0;
            end
            S_WB2: begin
                dr_we = r_wv;
            end
            S_L2_INST: begin
                l2_we = cnt_run;
            end
            S_L1_TO_L2: begin
                l2_we    = r_wv;
                l2_waddr = {l2_idx, r_widx};
                l2_wdata = l1_q;
            end
            S_L1_INST: begin
                l1_we = cnt_run;
            end
            S_WORD: begin
                l1_raddr = {l1_idx, off};
                l1_waddr = {l1_idx, off};
                l1_wdata = r_wdata;
                l1_we    = (r_act == ACT_WRITE);
            end
            default: ;
        endcase
    end

    tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(L1_LINE_COUNT * BLOCK_WORDS)) u_l1_data (
        .i_clk(i_clk), .i_we(l1_we), .i_waddr(l1_waddr), .i_wdata(l1_wdata),
        .i_raddr(l1_raddr), .o_rdata(l1_q)
    );

    tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(L2_LINE_COUNT * BLOCK_WORDS)) u_l2_data (
        .i_clk(i_clk), .i_we(l2_we), .i_waddr(l2_waddr), .i_wdata(l2_wdata),
        .i_raddr(l2_raddr), .o_rdata(l2_q)
    );

    tlwbc_ram #(.WIDTH(L2_TAG_W), .DEPTH(L2_LINE_COUNT)) u_l2_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(l2_idx), .i_wdata(l2_tag),
        .i_raddr(l2_idx), .o_rdata(tag_q)
    );

    tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_dram (
        .i_clk(i_clk), .i_we(dr_we), .i_waddr(dr_waddr), .i_wdata(dr_wdata),
        .i_raddr(dr_raddr), .o_rdata(dr_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_l1_valid  <= '0;
            r_l1_dirty  <= '0;
            r_l2_valid  <= '0;
            r_l2_dirty  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            // block copies: read at r_cnt, write in the following cycle at r_widx
            if (r_state == S_L2_RD || r_state == S_DR_RD || r_state == S_WB2 ||
                r_state == S_L1_TO_L2) begin
                r_wv   <= cnt_run;
                r_widx <= cidx;
                r_cnt  <= cnt_run ? r_cnt + 1'b1 : '0;
            end
            if (r_state == S_L2_INST || r_state == S_L1_INST) begin
                r_cnt <= cnt_run ? r_cnt + 1'b1 : '0;
            end
            if (r_wv && r_state == S_L2_RD) begin
                r_buf[r_widx] <= l2_q;
            end
            if (r_wv && r_state == S_DR_RD) begin
                r_buf[r_widx] <= dr_q;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MEMORY_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act    <= i_action;
                        r_addr   <= i_word_address;
                        r_wdata  <= i_write_data;
                        r_rdata  <= '0;
                        r_h1     <= 1'b0;
                        r_h2     <= 1'b0;
                        r_cost   <= '0;
                        r_err    <= 1'b0;
                        r_clear  <= 1'b0;
                        r_charge <= 1'b0;
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_l2_addr <= r_addr;
                    r_l2_wr   <= 1'b0;
                    r_l1vd    <= r_l1_valid[l1_idx] && r_l1_dirty[l1_idx];
                    r_vtag1   <= r_l1_tag[l1_idx];
                    if (r_act == ACT_CLEAR) begin
                        r_clear <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_act != ACT_READ && r_act != ACT_WRITE) begin
                        r_state <= S_DONE;
                    end else if ({1'b0, r_addr} >= (ADDR_W + 1)'(MEMORY_WORDS)) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_charge <= 1'b1;
                        if (r_l1_valid[l1_idx] && r_l1_tag[l1_idx] == l1_tag) begin
                            r_h1    <= 1'b1;
                            r_state <= S_WORD;
                        end else begin
                            r_state <= S_L2_TAG;
                        end
                    end
                end
                S_L2_TAG: begin
                    r_state <= S_L2_CHK;
                end
                S_L2_CHK: begin
                    r_vtag2   <= tag_q;
                    r_vdirty2 <= r_l2_valid[l2_idx] && r_l2_dirty[l2_idx];
                    if (!r_l2_wr) begin
                        r_h2 <= l2_hit;
                    end
                    if (l2_hit) begin
                        r_state <= r_l2_wr ? S_L1_TO_L2 : S_L2_RD;
                    end else begin
                        r_cost             <= r_cost + ACC_W'(costs.dram_rd);
                        r_l2_valid[l2_idx] <= 1'b1;
                        r_l2_dirty[l2_idx] <= 1'b0;
                        if (!r_l2_wr) begin
                            r_state <= S_DR_RD;
                        end else if (r_l2_valid[l2_idx] && r_l2_dirty[l2_idx]) begin
                            r_state <= S_WB2;
                        end else begin
                            r_state <= S_L1_TO_L2;
                        end
                    end
                end
                S_DR_RD: begin
                    if (!cnt_run) begin
                        r_state <= r_vdirty2 ? S_WB2 : S_L2_INST;
                    end
                end
                S_WB2: begin
                    if (!cnt_run) begin
                        r_cost  <= r_cost + ACC_W'(costs.dram_wr);
                        r_state <= r_l2_wr ? S_L1_TO_L2 : S_L2_INST;
                    end
                end
                S_L2_RD, S_L2_INST: begin
                    if (!cnt_run) begin
                        r_cost <= r_cost + ACC_W'(costs.l2_rd);
                        if (r_l1vd) begin
                            r_l2_addr <= {r_vtag1, l1_idx, OFF_W'(0)};
                            r_l2_wr   <= 1'b1;
                            r_state   <= S_L2_TAG;
                        end else begin
                            r_state <= S_L1_INST;
                        end
                    end
                end
                S_L1_TO_L2: begin
                    if (!cnt_run) begin
                        r_l2_dirty[l2_idx] <= 1'b1;
                        r_cost  <= r_cost + ACC_W'(costs.l2_wr);
                        r_state <= S_L1_INST;
                    end
                end
                S_L1_INST: begin
                    if (!cnt_run) begin
                        r_l1_tag[l1_idx]   <= l1_tag;
                        r_l1_valid[l1_idx] <= 1'b1;
                        r_l1_dirty[l1_idx] <= 1'b0;
                        r_state            <= S_WORD;
                    end
                end
                S_WORD: begin
                    if (r_act == ACT_WRITE) begin
                        r_l1_dirty[l1_idx] <= 1'b1;
                        r_cost  <= r_cost + ACC_W'(costs.l1_wr);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WORD_RD;
                    end
                end
                S_WORD_RD: begin
                    r_rdata <= l1_q;
                    r_cost  <= r_cost + ACC_W'(costs.l1_rd);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_total     <= n_total;
                        r_out_valid <= 1'b1;
                        r_out_rdata <= r_rdata;
                        r_out_h1    <= r_h1;
                        r_out_h2    <= r_h2;
                        r_out_cost  <= r_cost;
                        r_out_time  <= n_total;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_rdata;
    assign o_l1_hit        = r_out_h1;
    assign o_l2_hit        = r_out_h2;
    assign o_access_cost   = r_out_cost;
    assign o_elapsed_time  = r_out_time;
    assign o_address_error = r_out_err;

endmodule

// File: rtl/core/tlwbc_checker.sv
`timescale 1ns / 1ps

module tlwbc_checker
    import tlwbc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [DATA_W-1:0]    o_read_data,
    input logic                 o_l1_hit,
    input logic                 o_l2_hit,
    input logic [ACC_W-1:0]     o_access_cost,
    input logic [DATA_W-1:0]    o_elapsed_time,
    input logic                 o_address_error
);

    // a result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_elapsed_time)
            && $stable(o_access_cost) && $stable(o_read_data))
        else $error("result changed while stalled");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_l1_hit |-> !o_l2_hit)
        else $error("l1 and l2 hit together");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_address_error |-> !o_l1_hit && !o_l2_hit
            && o_access_cost == '0 && o_read_data == '0)
        else $error("address error with side effects");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not quiet after reset");

endmodule

bind two_level_write_back_cache_core tlwbc_checker u_tlwbc_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlwbc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              l1_hit;
        logic              l2_hit;
        logic [ACC_W-1:0]  access_cost;
        logic [DATA_W-1:0] elapsed;
        logic              address_error;
    } access_result_t;

    typedef bit [DATA_W-1:0] block_t [BLOCK_WORDS];

    class cache_scoreboard;
        bit [COST_W-1:0]   cost_reg [6];
        bit                l1_v [L1_LINE_COUNT];
        bit                l1_d [L1_LINE_COUNT];
        bit [L1_TAG_W-1:0] l1_t [L1_LINE_COUNT];
        bit [DATA_W-1:0]   l1_mem [L1_LINE_COUNT*BLOCK_WORDS];
        bit                l2_v [L2_LINE_COUNT];
        bit                l2_d [L2_LINE_COUNT];
        bit [L2_TAG_W-1:0] l2_t [L2_LINE_COUNT];
        bit [DATA_W-1:0]   l2_mem [L2_LINE_COUNT*BLOCK_WORDS];
        bit [DATA_W-1:0]   dram [MEMORY_WORDS];
        bit [DATA_W-1:0]   total;
        access_result_t    due_q [$];
        int                errors;
        int                checked;
        int                l1_hits;
        int                l2_hits;
        int                writebacks;

        function new();
            cost_reg[CFG_DRAM_RD] = 100;
            cost_reg[CFG_DRAM_WR] = 50;
            cost_reg[CFG_L2_RD]   = 10;
            cost_reg[CFG_L2_WR]   = 5;
            cost_reg[CFG_L1_RD]   = 1;
            cost_reg[CFG_L1_WR]   = 1;
            total = 0;
        endfunction

        function void set_cost(logic [CFG_IDX_W-1:0] idx, bit [COST_W-1:0] v);
            cost_reg[idx] = v;
        endfunction

        function void dram_xfer(int base, ref block_t blk, input bit wr,
                                ref bit [31:0] cost);
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                if (wr) begin
                    if (base + i < MEMORY_WORDS) dram[base+i] = blk[i];
                end else begin
                    blk[i] = (base + i < MEMORY_WORDS) ? dram[base+i] : '0;
                end
            end
            cost += wr ? cost_reg[CFG_DRAM_WR] : cost_reg[CFG_DRAM_RD];
        endfunction

        function bit l2_xfer(int a, ref block_t blk, input bit wr, ref bit [31:0] cost);
            int idx;
            int tag;
            int victim;
            bit hit;
            block_t tmp;
            block_t old;
            idx = (a / BLOCK_WORDS) % L2_LINE_COUNT;
            tag = a / (BLOCK_WORDS * L2_LINE_COUNT);
            hit = l2_v[idx] && l2_t[idx] == tag;
            if (!hit) begin
                dram_xfer(a - a % BLOCK_WORDS, tmp, 1'b0, cost);
                if (l2_v[idx] && l2_d[idx]) begin
                    victim = l2_t[idx] * (BLOCK_WORDS * L2_LINE_COUNT) + idx * BLOCK_WORDS;
                    for (int i = 0; i < BLOCK_WORDS; i++) old[i] = l2_mem[idx*BLOCK_WORDS+i];
                    dram_xfer(victim, old, 1'b1, cost);
                    writebacks++;
                end
                for (int i = 0; i < BLOCK_WORDS; i++) l2_mem[idx*BLOCK_WORDS+i] = tmp[i];
                l2_v[idx] = 1;
                l2_d[idx] = 0;
                l2_t[idx] = tag;
            end
            if (wr) begin
                for (int i = 0; i < BLOCK_WORDS; i++) l2_mem[idx*BLOCK_WORDS+i] = blk[i];
                l2_d[idx] = 1;
                cost += cost_reg[CFG_L2_WR];
            end else begin
                for (int i = 0; i < BLOCK_WORDS; i++) blk[i] = l2_mem[idx*BLOCK_WORDS+i];
                cost += cost_reg[CFG_L2_RD];
            end
            return hit;
        endfunction

        function void note_input(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                                 logic [DATA_W-1:0] wdata);
            access_result_t r;
            bit [31:0] cost;
            int idx;
            int tag;
            int off;
            int victim;
            block_t fill;
            block_t old;
            r = '{default: '0};
            cost = 0;
            if (act == ACT_CLEAR) begin
                total = 0;
            end else if (act == ACT_READ || act == ACT_WRITE) begin
                if (addr >= MEMORY_WORDS) begin
                    r.address_error = 1;
                end else begin
                    idx = (addr / BLOCK_WORDS) % L1_LINE_COUNT;
                    tag = addr / (BLOCK_WORDS * L1_LINE_COUNT);
                    off = addr % BLOCK_WORDS;
                    r.l1_hit = l1_v[idx] && l1_t[idx] == tag;
                    if (!r.l1_hit) begin
                        r.l2_hit = l2_xfer(addr, fill, 1'b0, cost);
                        if (l1_v[idx] && l1_d[idx]) begin
                            victim = l1_t[idx] * (BLOCK_WORDS * L1_LINE_COUNT)
                                     + idx * BLOCK_WORDS;
                            for (int i = 0; i < BLOCK_WORDS; i++)
                                old[i] = l1_mem[idx*BLOCK_WORDS+i];
                            void'(l2_xfer(victim, old, 1'b1, cost));
                        end
                        for (int i = 0; i < BLOCK_WORDS; i++) l1_mem[idx*BLOCK_WORDS+i] = fill[i];
                        l1_v[idx] = 1;
                        l1_d[idx] = 0;
                        l1_t[idx] = tag;
                    end
                    if (act == ACT_WRITE) begin
                        l1_mem[idx*BLOCK_WORDS+off] = wdata;
                        l1_d[idx] = 1;
                        cost += cost_reg[CFG_L1_WR];
                    end else begin
                        r.read_data = l1_mem[idx*BLOCK_WORDS+off];
                        cost += cost_reg[CFG_L1_RD];
                    end
                    total += cost;
                    if (r.l1_hit) l1_hits++;
                    if (r.l2_hit) l2_hits++;
                end
                r.elapsed = total;
            end else begin
                r.elapsed = total;
            end
            r.access_cost = cost[ACC_W-1:0];
            due_q.push_back(r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t want;
            if (due_q.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data exp %h got %h", $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.l1_hit !== want.l1_hit) begin
                $display("%0t: l1_hit exp %b got %b", $time, want.l1_hit, got.l1_hit);
                errors++;
            end
            if (got.l2_hit !== want.l2_hit) begin
                $display("%0t: l2_hit exp %b got %b", $time, want.l2_hit, got.l2_hit);
                errors++;
            end
            if (got.access_cost !== want.access_cost) begin
                $display("%0t: access_cost exp %0d got %0d", $time,
                         want.access_cost, got.access_cost);
                errors++;
            end
            if (got.elapsed !== want.elapsed) begin
                $display("%0t: elapsed_time exp %0d got %0d", $time, want.elapsed, got.elapsed);
                errors++;
            end
            if (got.address_error !== want.address_error) begin
                $display("%0t: address_error exp %b got %b", $time,
                         want.address_error, got.address_error);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COST_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action;
    logic [ADDR_W-1:0]    i_word_address;
    logic [DATA_W-1:0]    i_write_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [DATA_W-1:0]    o_read_data;
    logic                 o_l1_hit;
    logic                 o_l2_hit;
    logic [ACC_W-1:0]     o_access_cost;
    logic [DATA_W-1:0]    o_elapsed_time;
    logic                 o_address_error;

    two_level_write_back_cache_core dut (.*);

    cache_scoreboard sb = new();
    bit quiet;
    bit hold_req;
    int idle_cycles = 0;

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_action = ACT_READ;
        i_word_address = '0;
        i_write_data = '0;
        i_out_stall = 0;
    end

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check, then choose the stall for the next cycle
    initial begin
        int stall_left;
        access_result_t got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.read_data     = o_read_data;
                got.l1_hit        = o_l1_hit;
                got.l2_hit        = o_l2_hit;
                got.access_cost   = o_access_cost;
                got.elapsed       = o_elapsed_time;
                got.address_error = o_address_error;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 0;
                stall_left = 400;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: watchdog, nothing moving", $time);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic write_cost(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_cost(idx, v);
    endtask

    task automatic write_all_costs(int lo, int hi);
        write_cost(CFG_DRAM_RD, COST_W'($urandom_range(lo, hi)));
        write_cost(CFG_DRAM_WR, COST_W'($urandom_range(lo, hi)));
        write_cost(CFG_L2_RD, COST_W'($urandom_range(lo, hi)));
        write_cost(CFG_L2_WR, COST_W'($urandom_range(lo, hi)));
        write_cost(CFG_L1_RD, COST_W'($urandom_range(lo, hi)));
        write_cost(CFG_L1_WR, COST_W'($urandom_range(lo, hi)));
    endtask

    task automatic send_word(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                             logic [DATA_W-1:0] wdata);
        int gap;
        i_in_valid <= 1;
        i_action <= act;
        i_word_address <= addr;
        i_write_data <= wdata;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(act, addr, wdata);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        int r;
        logic [ACT_W-1:0] act;
        logic [ADDR_W-1:0] addr;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            act = r < 45 ? ACT_READ : r < 90 ? ACT_WRITE : r < 95 ? ACT_CLEAR : ACT_UNUSED;
            r = $urandom_range(0, 99);
            // hot region for hits, four l2 sets under sixteen tags for dirty evictions at both levels
            if (r < 40) addr = ADDR_W'($urandom_range(0, 511));
            else if (r < 75) addr = ADDR_W'($urandom_range(0, 15) * 2048
                                             + $urandom_range(0, 63));
            else addr = ADDR_W'($urandom_range(0, 32767));
            send_word(act, addr, $urandom());
        end
    endtask

    initial begin
        quiet = 0;
        hold_req = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, conflicts at both levels, clear, unused code
        send_word(ACT_WRITE, 0, 32'hFFFF_FFFF);
        send_word(ACT_READ, 0, 0);
        send_word(ACT_WRITE, 15'h7FFF, 0);
        send_word(ACT_READ, 15'h7FFF, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 256, 32'h1234_5678);
        send_word(ACT_READ, 0, 0);
        send_word(ACT_WRITE, 2048, 32'hA5A5_5A5A);
        send_word(ACT_WRITE, 4096, 32'h5A5A_A5A5);
        send_word(ACT_WRITE, 2048 + 256, 32'h0F0F_0F0F);
        send_word(ACT_READ, 0, 0);
        send_word(ACT_READ, 2048, 0);
        send_word(ACT_READ, 4096, 0);
        send_word(ACT_READ, 256, 0);
        send_word(ACT_CLEAR, 15'h7FFF, 32'hFFFF_FFFF);
        send_word(ACT_UNUSED, 15'h7FFF, 32'hFFFF_FFFF);
        send_word(ACT_READ, 5, 0);
        send_word(ACT_WRITE, 17, 32'h5555_5555);
        send_word(ACT_READ, 17, 0);
        send_word(ACT_READ, 15'h7FF0, 0);
        drain();

        write_all_costs(1023, 1023);
        random_words(375);
        drain();

        write_all_costs(0, 0);
        quiet = 1;
        random_words(375);
        quiet = 0;
        drain();

        write_all_costs(0, 1023);
        random_words(100);
        hold_req = 1;
        random_words(275);
        drain();

        write_all_costs(0, 40);
        random_words(375);
        drain();
        repeat (200) @(posedge i_clk);

        $display("tb: %0d results checked, %0d l1 hits, %0d l2 hits, %0d dram write-backs",
                 sb.checked, sb.l1_hits, sb.l2_hits, sb.writebacks);
        $display("tb: cost settings covered defaults, all zero, all max and random");
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
